### sv/fatts_pkg.sv
// shared types, constants and calendar helpers for the fat timestamp packer
package fatts_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CFG_W    = 8;

  // offset register, biased quarter hours
  localparam logic [CFG_W-1:0] OFFSET_RESET = 8'd48;
  localparam logic [CFG_W-1:0] OFFSET_MAX   = 8'd104;
  localparam logic [CFG_W-1:0] OFFSET_BIAS  = 8'd48;

  // calendar limits
  localparam logic [YEAR_W-1:0] YEAR_MIN     = 12'd1980;
  localparam logic [YEAR_W-1:0] YEAR_MAX     = 12'd2107;
  localparam logic [YEAR_W-1:0] YEAR_NO_LEAP = 12'd2100;
  localparam int unsigned       MIN_PER_DAY  = 1440;

  // fallback stamp 2024-01-01 00:00
  localparam logic [WORD_W-1:0] FALLBACK_DATE = 16'((2024 - 1980) << 9 | (1 << 5) | 1);
  localparam logic [WORD_W-1:0] FALLBACK_TIME = 16'd0;

  typedef struct packed {
    logic                clock_valid;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } fatts_item_t;

  // leap rule for years 1979..2108: the only century year there not a leap is 2100
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != YEAR_NO_LEAP);
  endfunction

  // month length, zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap_year(y) ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### sv/fat_timestamp_with_utc_offset.sv
// top level: fat timestamp packer with utc offset register and two-stage pipeline
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    clock_valid, utc year, month, day, hour, minute
//   out      output     out_valid / out_ready  fat_date, fat_time
//   cfg      input      cfg_wr_en              cfg_wr_data (biased quarter-hour offset)
//
// one item per cycle sustained unless out_ready stalls the output; input register then result
// register, with the whole conversion in the logic between them
// rst_n is synchronous; it empties both stages and sets the offset to 48 (no offset)
// a stalled output holds its item while the input stage still takes one more item;
// in_ready drops only when both stages are full and out_ready is low
module fat_timestamp_with_utc_offset (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_clock_valid,
  input  logic [fatts_pkg::YEAR_W-1:0]   in_utc_year,
  input  logic [fatts_pkg::MONTH_W-1:0]  in_utc_month,
  input  logic [fatts_pkg::DAY_W-1:0]    in_utc_day,
  input  logic [fatts_pkg::HOUR_W-1:0]   in_utc_hour,
  input  logic [fatts_pkg::MINUTE_W-1:0] in_utc_minute,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fatts_pkg::WORD_W-1:0]   out_fat_date,
  output logic [fatts_pkg::WORD_W-1:0]   out_fat_time,
  input  logic                          cfg_wr_en,
  input  logic [fatts_pkg::CFG_W-1:0]    cfg_wr_data
);
  import fatts_pkg::*;

  logic                s1_v_r;
  fatts_item_t         s1_item_r;
  logic                s2_v_r;
  logic [WORD_W-1:0]   date_r;
  logic [WORD_W-1:0]   time_r;
  logic [CFG_W-1:0]    offset_r;
  logic                s2_ready;
  logic [WORD_W-1:0]   date_nxt;
  logic [WORD_W-1:0]   time_nxt;

  // stage flow control
  assign s2_ready = !s2_v_r || out_ready;
  assign in_ready = !s1_v_r || s2_ready;

  // control state and offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      offset_r <= OFFSET_RESET;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (cfg_wr_en) begin
        offset_r <= cfg_wr_data;
      end
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{clock_valid: in_clock_valid, year: in_utc_year, month: in_utc_month,
                     day: in_utc_day, hour: in_utc_hour, minute: in_utc_minute};
    end
  end

  // conversion
  fatts_conv u_conv (
    .item     (s1_item_r),
    .offset_q (offset_r),
    .fat_date (date_nxt),
    .fat_time (time_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      date_r <= date_nxt;
      time_r <= time_nxt;
    end
  end

  assign out_valid    = s2_v_r;
  assign out_fat_date = date_r;
  assign out_fat_time = time_r;

endmodule

### sv/fatts_conv.sv
// combinational offset apply, day roll and fat word packing
module fatts_conv (
  input  fatts_pkg::fatts_item_t        item,
  input  logic [fatts_pkg::CFG_W-1:0]   offset_q,
  output logic [fatts_pkg::WORD_W-1:0]  fat_date,
  output logic [fatts_pkg::WORD_W-1:0]  fat_time
);
  import fatts_pkg::*;

  logic [CFG_W-1:0]      q_cl;
  logic signed [7:0]     off_q;
  logic signed [12:0]    off_min;
  logic [10:0]           day_min;
  logic signed [12:0]    local_min;
  logic                  neg;
  logic                  over;
  logic signed [12:0]    adj_s;
  logic [10:0]           adj;
  logic [21:0]           hq;
  logic [HOUR_W-1:0]     hour_o;
  logic [10:0]           hour_x60;
  logic [MINUTE_W-1:0]   min_o;
  logic [DAY_W-1:0]      md_cur;
  logic [DAY_W-1:0]      md_prev;
  logic [MONTH_W-1:0]    mo_prev;
  logic [YEAR_W-1:0]     y_prev;
  logic                  in_ok;
  logic [YEAR_W-1:0]     y_new;
  logic [MONTH_W-1:0]    mo_new;
  logic [DAY_W-1:0]      d_new;
  logic                  out_ok;
  logic [YEAR_W-1:0]     y_rel;

  // clamp and unbias the offset, scale to minutes
  assign q_cl    = (offset_q > OFFSET_MAX) ? OFFSET_MAX : offset_q;
  assign off_q   = $signed(q_cl - OFFSET_BIAS);
  assign off_min = 13'(off_q) * 13'sd15;

  // input reading check
  assign md_cur = month_days(item.year, item.month);
  assign in_ok  = item.clock_valid && (item.year >= YEAR_MIN) && (item.year <= YEAR_MAX) &&
                  (item.hour <= 5'd23) && (item.minute <= 6'd59) && (md_cur != 5'd0) &&
                  (item.day != 5'd0) && (item.day <= md_cur);

  // minute of day with offset, wrapped into one day
  assign day_min   = 11'(item.hour) * 11'd60 + 11'(item.minute);
  assign local_min = $signed({2'b00, day_min}) + off_min;
  assign neg       = local_min[12];
  assign over      = !neg && (local_min >= 13'sd1440);

  always_comb begin
    priority if (neg) begin
      adj_s = local_min + 13'(MIN_PER_DAY);
    end else if (over) begin
      adj_s = local_min - 13'(MIN_PER_DAY);
    end else begin
      adj_s = local_min;
    end
  end
  assign adj = adj_s[10:0];

  // hour by reciprocal of 60, exact below 1440
  assign hq       = 22'(adj) * 22'd1093;
  assign hour_o   = hq[20:16];
  assign hour_x60 = 11'(hour_o) * 11'd60;
  assign min_o    = 6'(adj - hour_x60);

  // previous month for a backward roll
  assign mo_prev = (item.month > 4'd1) ? item.month - 4'd1 : 4'd12;
  assign y_prev  = (item.month > 4'd1) ? item.year : item.year - 12'd1;
  assign md_prev = month_days(y_prev, mo_prev);

  // one-day roll of the date
  always_comb begin
    y_new  = item.year;
    mo_new = item.month;
    d_new  = item.day;
    priority if (neg) begin
      if (item.day > 5'd1) begin
        d_new = item.day - 5'd1;
      end else begin
        y_new  = y_prev;
        mo_new = mo_prev;
        d_new  = md_prev;
      end
    end else if (over) begin
      if (item.day < md_cur) begin
        d_new = item.day + 5'd1;
      end else begin
        d_new = 5'd1;
        if (item.month < 4'd12) begin
          mo_new = item.month + 4'd1;
        end else begin
          mo_new = 4'd1;
          y_new  = item.year + 12'd1;
        end
      end
    end
  end

  // after the roll only the year can leave its range
  assign out_ok = in_ok && (y_new >= YEAR_MIN) && (y_new <= YEAR_MAX);
  assign y_rel  = y_new - YEAR_MIN;

  // pack, or give the fallback stamp
  assign fat_date = out_ok ? {y_rel[6:0], mo_new, d_new} : FALLBACK_DATE;
  assign fat_time = out_ok ? {hour_o, min_o, 5'd0} : FALLBACK_TIME;

endmodule
